@@ design/dkl_pkg.sv @@
// dkl_pkg: shared types, constants and step functions for the keyed LFSR
// word transform. No dependencies.
package dkl_pkg;

  localparam logic [31:0] K_FEED  = 32'h8050_0062;
  localparam logic [31:0] K_MIX_A = 32'h5B2C_004A;
  localparam logic [31:0] K_MIX_B = 32'h8034_25C3;

  localparam logic [11:0] TAPS [4] = '{12'h480, 12'h4A0, 12'h580, 12'h5A0};

  localparam int KG_STAGES   = 3;   // key derivation register stages
  localparam int KG_STEPS    = 4;   // LFSR steps per lane per stage
  localparam int XF_STEPS    = 3;   // transform steps per stage
  localparam int XF_STAGES   = 13;  // 39 steps total
  localparam int LATENCY     = KG_STAGES + 2 * XF_STAGES + 3;

  typedef struct packed {
    logic [63:0] tbl;
    logic [1:0]  order;
    logic        inv;
    logic [31:0] nmask;
    logic [11:0] start;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic        kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
  } tok_t;

  typedef struct packed {
    logic [11:0] r;
    logic [31:0] d;
    logic [1:0]  sel;
  } xf_st_t;

  function automatic logic table_bit(logic [63:0] tbl, logic [1:0] order, logic [4:0] i);
    logic [5:0] idx;
    case (order)
      2'd0: idx = {i[4:3], 1'b0, ~i[2:0]};
      2'd1: idx = {i[4:2], ~i[2:0]};
      2'd2: idx = {1'b0, i[4:3], ~i[2:0]};
      default: idx = {1'b0, i[4:3], i[2:0]};
    endcase
    return tbl[idx];
  endfunction

  // returns {output bit, next register}
  function automatic logic [12:0] lfsr_step(logic [11:0] r, logic [4:0] sel, key_t k);
    logic [11:0] r2;
    logic [11:0] rn;
    logic        fb;
    logic        tb;
    fb = ^(r & TAPS[sel[2:1]]);
    r2 = r ^ {9'b0, sel[0], 2'b00};
    tb = table_bit(k.tbl, k.order, sel) ^ k.inv;
    rn = {r2[10:0], fb ^ tb};
    rn[0] = rn[0] ^ k.nmask[sel];
    return {rn[11] ^ tb, rn};
  endfunction

  function automatic xf_st_t xf_step(xf_st_t st, key_t k);
    logic [7:0]  byte_v;
    logic [12:0] lr;
    logic [31:0] sh;
    xf_st_t      o;
    byte_v = 8'(st.d >> {st.sel, 3'b000});
    lr     = lfsr_step(st.r, byte_v[4:0], k);
    sh     = {1'b0, st.d[31:1]};
    o.r    = lr[11:0];
    o.sel  = {st.d[0], lr[12]};
    o.d    = (st.d[0] == lr[12]) ? sh : (sh ^ K_FEED);
    return o;
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  // returns {a, b}
  function automatic logic [63:0] pre_mix(logic [31:0] a_in, logic [31:0] b_in);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    a = a_in;
    b = b_in;
    for (int k = 0; k < 6; k++) begin
      t = rotl32(a ^ K_MIX_A, 5'(25 - 5 * k)) ^ b;
      b = a;
      a = t;
    end
    return {a, b};
  endfunction

  function automatic logic [63:0] mid_mix(logic [31:0] a_in, logic [31:0] b_in);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    a = a_in;
    b = b_in;
    for (int k = 0; k < 6; k++) begin
      t = rotl32(a ^ K_MIX_B, 5'(10 - 2 * k)) ^ b;
      b = a;
      a = t;
    end
    return {a, b};
  endfunction

endpackage

@@ design/dkl_keygen.sv @@
// dkl_keygen: three-stage key derivation, 32 LFSR lanes of 12 steps each.
// Depends on dkl_pkg.
module dkl_keygen import dkl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        kind,
  input  logic [63:0] sec_bytes,
  input  logic [7:0]  col_mask,
  input  logic [7:0]  init_vector,
  input  logic [1:0]  bit_order,
  input  logic [63:0] payload,
  output logic        out_valid,
  output tok_t        out_tok
);

  // stage 0/1 side data
  logic        v0, v1;
  key_t        k0, k1;
  logic [7:0]  pcm0, pcm1;
  logic        fb0, fb1;
  logic [31:0] pat0, pat1;
  logic        kind0, kind1;
  logic [63:0] pl0, pl1;
  logic [11:0] lane0 [32];
  logic [11:0] lane1 [32];

  logic        fb_c;
  logic [7:0]  pcm_c;
  logic [7:0]  lo;
  logic [31:0] pat_c;
  key_t        k_c;
  logic [11:0] lane0_next [32];
  logic [11:0] lane1_next [32];
  logic [31:0] mask_c;
  tok_t        tok_next;

  always_comb begin
    logic [11:0] r;
    logic [12:0] lr;
    fb_c  = ~table_bit(sec_bytes, bit_order, 5'd0);
    pcm_c = fb_c ? col_mask : ~col_mask;
    lo    = {~init_vector[0], init_vector[0], ~init_vector[1], init_vector[1],
             ~init_vector[2], init_vector[2], ~init_vector[3], init_vector[3]};
    pat_c = {~lo, ~lo, lo, lo};
    for (int b = 0; b < 8; b++) begin
      pat_c[8 + b]  = pat_c[8 + b] ^ table_bit(sec_bytes, bit_order, 5'(b + 8))
                      ^ init_vector[4];
      pat_c[24 + b] = pat_c[24 + b] ^ table_bit(sec_bytes, bit_order, 5'(b + 24))
                      ^ init_vector[4];
    end
    k_c.tbl   = sec_bytes;
    k_c.order = bit_order;
    k_c.inv   = init_vector[5];
    k_c.nmask = '0;
    k_c.start = '0;
    for (int i = 0; i < 32; i++) begin
      r = {1'b0, pcm_c, 3'b000};
      for (int s = 0; s < KG_STEPS; s++) begin
        lr = lfsr_step(r, 5'(i), k_c);
        r  = lr[11:0];
      end
      lane0_next[i] = r;
    end
  end

  always_comb begin
    logic [11:0] r;
    logic [12:0] lr;
    for (int i = 0; i < 32; i++) begin
      r = lane0[i];
      for (int s = 0; s < KG_STEPS; s++) begin
        lr = lfsr_step(r, 5'(i), k0);
        r  = lr[11:0];
      end
      lane1_next[i] = r;
    end
  end

  // last stage: finish the runs and fold them into the mask
  always_comb begin
    logic [12:0] lr;
    for (int i = 0; i < 32; i++) begin
      lr = {1'b0, lane1[i]};
      for (int s = 0; s < KG_STEPS; s++) lr = lfsr_step(lr[11:0], 5'(i), k1);
      mask_c[i] = table_bit(k1.tbl, k1.order, 5'(i)) ^ 1'(i) ^ pat1[i] ^ lr[12];
    end
    tok_next.key       = k1;
    tok_next.key.nmask = mask_c;
    tok_next.key.start = {1'b0, pcm1, fb1, fb1, fb1};
    tok_next.kind      = kind1;
    tok_next.a         = pl1[31:0];
    tok_next.b         = pl1[63:32];
    tok_next.x         = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      out_valid <= v1;
    end
    k0 <= k_c;     pcm0 <= pcm_c; fb0 <= fb_c; pat0 <= pat_c;
    kind0 <= kind; pl0 <= payload; lane0 <= lane0_next;
    k1 <= k0;      pcm1 <= pcm0;  fb1 <= fb0;  pat1 <= pat0;
    kind1 <= kind0; pl1 <= pl0;   lane1 <= lane1_next;
    out_tok <= tok_next;
  end

endmodule

@@ design/dkl_xform.sv @@
// dkl_xform: 39-step keyed LFSR word transform, three steps per stage.
// Transforms tok.a into tok.x, carries the rest. Depends on dkl_pkg.
module dkl_xform import dkl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  tok_t in_tok,
  output logic out_valid,
  output tok_t out_tok
);

  xf_st_t st      [XF_STAGES];
  tok_t   tk      [XF_STAGES];
  logic   vld     [XF_STAGES];
  xf_st_t src_st  [XF_STAGES];
  tok_t   src_tk  [XF_STAGES];
  logic   src_vld [XF_STAGES];

  assign src_st[0]  = '{r: in_tok.key.start, d: in_tok.a, sel: 2'b00};
  assign src_tk[0]  = in_tok;
  assign src_vld[0] = in_valid;

  for (genvar g = 1; g < XF_STAGES; g++) begin : g_link
    assign src_st[g]  = st[g-1];
    assign src_tk[g]  = tk[g-1];
    assign src_vld[g] = vld[g-1];
  end

  for (genvar g = 0; g < XF_STAGES; g++) begin : g_stage
    xf_st_t st_next;
    always_comb begin
      st_next = src_st[g];
      for (int s = 0; s < XF_STEPS; s++) st_next = xf_step(st_next, src_tk[g].key);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= src_vld[g];
      end
      st[g] <= st_next;
      tk[g] <= src_tk[g];
    end
  end

  always_comb begin
    out_tok   = tk[XF_STAGES-1];
    out_tok.x = st[XF_STAGES-1].d;
  end
  assign out_valid = vld[XF_STAGES-1];

endmodule

@@ design/dongle_keyed_lfsr_word_transform_top.sv @@
// Top level of the keyed LFSR word transform / block decode pipeline.
// Depends on dkl_pkg, dkl_keygen, dkl_xform.
//
// Usage: drive kind, sec_bytes, col_mask, init_vector, bit_order and payload
// with start high; the word is taken at that edge when busy is low. busy is
// always low: the pipeline takes one word every cycle.
// Each word carries its own key; nothing persists between words.
// Pipeline: 32 register stages; done is high together with result_value.
// Key derivation takes 3 stages (32 LFSR lanes, 4 steps per stage); each
// of the two 39-step transforms takes 13 stages at 3 steps per stage;
// pre-mix, mid-mix and output take one stage each.
// The word kind goes through the same path, so latency is fixed and results
// come out in input order.
// done is high for exactly one cycle per word; the receiver cannot stall,
// so no backpressure exists and nothing is buffered.
// Reset (rst, synchronous) clears all valid bits; words in flight are dropped.
module dongle_keyed_lfsr_word_transform_top import dkl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [63:0] sec_bytes,
  input  logic [7:0]  col_mask,
  input  logic [7:0]  init_vector,
  input  logic [1:0]  bit_order,
  input  logic [63:0] payload,
  output logic        done,
  output logic [63:0] result_value
);

  logic kg_valid, x1_valid, x2_valid;
  tok_t kg_tok, x1_tok, x2_tok;
  logic p_valid, m_valid;
  tok_t p_tok, m_tok, p_next, m_next;
  logic [63:0] result_next;

  assign busy = 1'b0;

  dkl_keygen u_keygen (
    .clk, .rst,
    .in_valid(start & ~busy),
    .kind, .sec_bytes, .col_mask, .init_vector, .bit_order, .payload,
    .out_valid(kg_valid), .out_tok(kg_tok)
  );

  always_comb begin
    logic [63:0] ab;
    p_next = kg_tok;
    ab = pre_mix(kg_tok.a, kg_tok.b);
    if (kg_tok.kind) begin
      p_next.a = ab[63:32];
      p_next.b = ab[31:0];
    end
  end

  dkl_xform u_xf1 (
    .clk, .rst,
    .in_valid(p_valid), .in_tok(p_tok),
    .out_valid(x1_valid), .out_tok(x1_tok)
  );

  // word kind parks its result in b; the second transform runs on don't-care a
  always_comb begin
    logic [63:0] ab;
    m_next = x1_tok;
    ab = mid_mix(x1_tok.x ^ x1_tok.b, x1_tok.a);
    if (x1_tok.kind) begin
      m_next.a = ab[63:32];
      m_next.b = ab[31:0];
    end else begin
      m_next.b = x1_tok.x;
    end
  end

  dkl_xform u_xf2 (
    .clk, .rst,
    .in_valid(m_valid), .in_tok(m_tok),
    .out_valid(x2_valid), .out_tok(x2_tok)
  );

  assign result_next = x2_tok.kind ? {x2_tok.a, x2_tok.x ^ x2_tok.b}
                                   : {32'b0, x2_tok.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      m_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= kg_valid;
      m_valid <= x1_valid;
      done    <= x2_valid;
    end
    p_tok        <= p_next;
    m_tok        <= m_next;
    result_value <= result_next;
  end

endmodule

@@ design/dkl_checker.sv @@
// dkl_checker: port-level assertions for the top level, bound in below.
// Depends on dkl_pkg and dongle_keyed_lfsr_word_transform_top.
module dkl_checker import dkl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        kind,
  input logic        done,
  input logic [63:0] result_value
);

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without a word taken");

  a_word_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(kind, LATENCY)) |-> (result_value[63:32] == 32'b0))
    else $error("word result upper half not zero");

endmodule

bind dongle_keyed_lfsr_word_transform_top dkl_checker u_dkl_checker (.*);
